// ===== src/htr_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
// Holds the beat structs, the pipeline depth, the reciprocal constants and the sector codes.
// No dependencies.
package htr_pkg;

  // Input beat: hue in degrees, saturation and value in percent.
  typedef struct packed {
    logic [15:0] hue_deg;
    logic [6:0]  sat_pct;
    logic [6:0]  val_pct;
  } hsv_in_t;

  // Output beat: one 8-bit level per channel.
  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } rgb_out_t;

  // Hand-off from the front half (levels and hue split) to the back half.
  typedef struct packed {
    logic [7:0] top;
    logic [7:0] bottom;
    logic [2:0] sector;
    logic [5:0] rem;
  } front_out_t;

  // Pipeline geometry.
  localparam int NumStages   = 6;
  localparam int FrontStages = 3;

  // Fixed arithmetic constants.
  localparam logic [15:0] FullTurn   = 16'd360;
  localparam logic [6:0]  PctFull    = 7'd100;

  // Reciprocals, each checked to give an exact floor over its input range.
  // floor(x / 360) for x < 65536: (x * 46604) >> 24.
  localparam logic [31:0] HueRecip   = 32'd46604;
  // floor(x / 5) for x <= 1275: (x * 1639) >> 13.
  localparam logic [20:0] FiveRecip  = 21'd1639;
  // floor(x / 100) for x <= 25500: (x * 5243) >> 19.
  localparam logic [27:0] PctRecip   = 28'd5243;
  // floor(x / 60) for x <= 15045: (x * 17477) >> 20.
  localparam logic [28:0] SpanRecip  = 29'd17477;

  // Hue sectors, sixty degrees each.
  localparam logic [2:0] SecRedYel = 3'd0;
  localparam logic [2:0] SecYelGrn = 3'd1;
  localparam logic [2:0] SecGrnCyn = 3'd2;
  localparam logic [2:0] SecCynBlu = 3'd3;
  localparam logic [2:0] SecBluMag = 3'd4;
  localparam logic [2:0] SecMagRed = 3'd5;

  // Percentages above full scale are taken as full scale.
  function automatic logic [6:0] clamp_pct(input logic [6:0] raw);
    return (raw > PctFull) ? PctFull : raw;
  endfunction

endpackage

// ===== src/htr_pipe_ctrl.sv =====
// Valid and ready control for the converter pipeline.
// Keeps one valid bit per stage and lets bubbles collapse under a stall.
// Depends on htr_pkg for the stage count.
module htr_pipe_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [htr_pkg::NumStages-1:0] load_o
);
  import htr_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   ready;

  // A stage may take a new beat when it is empty or its content moves on.
  always_comb begin
    ready[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  // Valid bits follow the data one stage per load.
  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign load_o      = ready[NumStages-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

// ===== src/htr_front.sv =====
// Front half of the converter: three stages that reduce the hue, split it into
// sector and remainder, and scale value and saturation into top and bottom levels.
// Depends on htr_pkg.
module htr_front (
  input  logic                              clk_i,
  input  logic [htr_pkg::FrontStages-1:0]   load_i,
  input  htr_pkg::hsv_in_t                  in_data_i,
  output htr_pkg::front_out_t               front_o
);
  import htr_pkg::*;

  // Stage 1: quotient of hue by 360, clamped inputs, top level.
  logic [31:0] hue_prod;
  logic [6:0]  val_c;
  logic [12:0] val51;
  logic [10:0] val51_div4;
  logic [20:0] top_prod;
  logic [15:0] hue_q1;
  logic [7:0]  quo_q1;
  logic [6:0]  sat_q1;
  logic [7:0]  top_q1;

  assign hue_prod   = 32'(in_data_i.hue_deg) * HueRecip;
  assign val_c      = clamp_pct(in_data_i.val_pct);
  // v * 255 / 100 is v * 51 / 20: multiply by 51, drop two bits, divide by 5.
  assign val51      = (13'(val_c) << 5) + (13'(val_c) << 4) + (13'(val_c) << 1) + 13'(val_c);
  assign val51_div4 = val51[12:2];
  assign top_prod   = 21'(val51_div4) * FiveRecip;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      hue_q1 <= in_data_i.hue_deg;
      quo_q1 <= hue_prod[31:24];
      sat_q1 <= clamp_pct(in_data_i.sat_pct);
      top_q1 <= top_prod[20:13];
    end
  end

  // Stage 2: reduced hue and top times the complement of saturation.
  logic [15:0] turns;
  logic [15:0] hue_red;
  logic [14:0] bot_prod;
  logic [8:0]  hue_q2;
  logic [7:0]  top_q2;
  logic [14:0] bot_prod_q2;

  assign turns    = 16'(quo_q1) * FullTurn;
  assign hue_red  = hue_q1 - turns;
  assign bot_prod = 15'(top_q1) * 15'(PctFull - sat_q1);

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      hue_q2      <= hue_red[8:0];
      top_q2      <= top_q1;
      bot_prod_q2 <= bot_prod;
    end
  end

  // Stage 3: sector by threshold compare, bottom level by reciprocal of 100.
  logic [2:0]  sector;
  logic [8:0]  base;
  logic [8:0]  rem_full;
  logic [27:0] bot_scaled;
  front_out_t  front_q3;

  always_comb begin
    if (hue_q2 >= 9'd300) begin
      sector = SecMagRed;
      base   = 9'd300;
    end else if (hue_q2 >= 9'd240) begin
      sector = SecBluMag;
      base   = 9'd240;
    end else if (hue_q2 >= 9'd180) begin
      sector = SecCynBlu;
      base   = 9'd180;
    end else if (hue_q2 >= 9'd120) begin
      sector = SecGrnCyn;
      base   = 9'd120;
    end else if (hue_q2 >= 9'd60) begin
      sector = SecYelGrn;
      base   = 9'd60;
    end else begin
      sector = SecRedYel;
      base   = 9'd0;
    end
  end

  assign rem_full   = hue_q2 - base;
  assign bot_scaled = 28'(bot_prod_q2) * PctRecip;

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      front_q3.top    <= top_q2;
      front_q3.bottom <= bot_scaled[26:19];
      front_q3.sector <= sector;
      front_q3.rem    <= rem_full[5:0];
    end
  end

  assign front_o = front_q3;

endmodule

// ===== src/htr_back.sv =====
// Back half of the converter: three stages that form the ramp between the
// bottom and top levels and route the levels to the channels by sector.
// Depends on htr_pkg.
module htr_back (
  input  logic                                          clk_i,
  input  logic [htr_pkg::NumStages-htr_pkg::FrontStages-1:0] load_i,
  input  htr_pkg::front_out_t                           front_i,
  output htr_pkg::rgb_out_t                             out_data_o
);
  import htr_pkg::*;

  // Stage 4: span between the levels times the remainder.
  logic [7:0]  span;
  logic [7:0]  top_q4;
  logic [7:0]  bottom_q4;
  logic [2:0]  sector_q4;
  logic [13:0] ramp_prod_q4;

  assign span = front_i.top - front_i.bottom;

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      top_q4       <= front_i.top;
      bottom_q4    <= front_i.bottom;
      sector_q4    <= front_i.sector;
      ramp_prod_q4 <= 14'(span) * 14'(front_i.rem);
    end
  end

  // Stage 5: divide by the sector span of 60 through its reciprocal.
  logic [28:0] ramp_scaled;
  logic [7:0]  top_q5;
  logic [7:0]  bottom_q5;
  logic [2:0]  sector_q5;
  logic [7:0]  ramp_q5;

  assign ramp_scaled = 29'(ramp_prod_q4) * SpanRecip;

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      top_q5    <= top_q4;
      bottom_q5 <= bottom_q4;
      sector_q5 <= sector_q4;
      ramp_q5   <= ramp_scaled[27:20];
    end
  end

  // Stage 6: rising and falling levels, then the sector routing.
  logic [7:0] rise;
  logic [7:0] fall;
  rgb_out_t   rgb;
  rgb_out_t   out_q6;

  assign rise = bottom_q5 + ramp_q5;
  assign fall = top_q5 - ramp_q5;

  always_comb begin
    case (sector_q5)
      SecRedYel: begin
        rgb = '{red_level: top_q5, green_level: rise, blue_level: bottom_q5};
      end
      SecYelGrn: begin
        rgb = '{red_level: fall, green_level: top_q5, blue_level: bottom_q5};
      end
      SecGrnCyn: begin
        rgb = '{red_level: bottom_q5, green_level: top_q5, blue_level: rise};
      end
      SecCynBlu: begin
        rgb = '{red_level: bottom_q5, green_level: fall, blue_level: top_q5};
      end
      SecBluMag: begin
        rgb = '{red_level: rise, green_level: bottom_q5, blue_level: top_q5};
      end
      SecMagRed: begin
        rgb = '{red_level: top_q5, green_level: bottom_q5, blue_level: fall};
      end
      default: begin
        rgb = '{red_level: top_q5, green_level: bottom_q5, blue_level: fall};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      out_q6 <= rgb;
    end
  end

  assign out_data_o = out_q6;

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level.
// Instantiates the pipeline control and the front and back datapath halves.
// Depends on htr_pkg, htr_pipe_ctrl, htr_front and htr_back.
//
// Usage:
//   The input channel (in_valid_i, in_ready_o, in_data_i) takes one beat per
//   pixel: hue in degrees (any 16-bit value, reduced modulo 360), saturation
//   and value in percent (above 100 read as 100). The output channel
//   (out_valid_o, out_ready_i, out_data_o) returns one beat of 8-bit red,
//   green and blue levels for every input beat, in order.
//   An accepted beat moves through the six register stages to out_valid_o.
//   Throughput is one beat per cycle while the receiver is ready; no stage
//   has more than one multiplication, by a constant or by a level, on a path.
//   Reset clears the stage valid bits only; the block is ready in the first
//   cycle after reset. When the receiver stalls, the output beat holds and the
//   stages behind it keep filling empty slots, so in_ready_o falls only once
//   every stage holds a beat. No beat is dropped or repeated.
module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htr_pkg::hsv_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output htr_pkg::rgb_out_t out_data_o
);
  import htr_pkg::*;

  logic [NumStages-1:0] load;
  front_out_t           front;

  htr_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .load_o      (load)
  );

  htr_front u_front (
    .clk_i     (clk_i),
    .load_i    (load[FrontStages-1:0]),
    .in_data_i (in_data_i),
    .front_o   (front)
  );

  htr_back u_back (
    .clk_i      (clk_i),
    .load_i     (load[NumStages-1:FrontStages]),
    .front_i    (front),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/htr_checker.sv =====
// Port-level checks for the HSV to RGB converter, with the bind that attaches them.
// Depends on htr_pkg and the top level hsv_to_rgb_converter.
module htr_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  htr_pkg::rgb_out_t out_data_o
);
  import htr_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  // A stalled output beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed or vanished under a stall");

  // A ready receiver lets the whole pipeline move, so the input is ready too.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while the receiver was ready");

  // With nothing waiting at the output, some stage is free for a new beat.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no output beat pending");

  // An accepted beat reaches the output when the receiver stays ready and reset stays released.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_beat, 6) && out_ready_i && $past(out_ready_i, 1) && $past(out_ready_i, 2)
     && $past(out_ready_i, 3) && $past(out_ready_i, 4) && $past(out_ready_i, 5)
     && $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3)
     && $past(rst_ni, 4) && $past(rst_ni, 5) && $past(rst_ni, 6)) |-> out_valid_o)
    else $error("accepted beat did not reach the output in six cycles");

endmodule

bind hsv_to_rgb_converter htr_checker u_htr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
